// File: rtl/lru_page_cache_directory_core_macros.svh
// ----------------------------------------------------------------------------
// lru_page_cache_directory_core_macros
// Assertion macros for the page directory core.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_CACHE_DIRECTORY_CORE_MACROS_SVH
`define LRU_PAGE_CACHE_DIRECTORY_CORE_MACROS_SVH
// Implication check, disabled during reset.
`define LPCD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication check, disabled during reset.
`define LPCD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/lpcd_pkg.sv
// ----------------------------------------------------------------------------
// lpcd_pkg
// Types and constants of the LRU page directory.
// ----------------------------------------------------------------------------
package lpcd_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int MAX_RESULTS  = 16;

    typedef enum logic [2:0] {
        KIND_LOOKUP = 3'd0,
        KIND_PROBE  = 3'd1,
        KIND_PUT    = 3'd2,
        KIND_MARK   = 3'd3,
        KIND_SCAN   = 3'd4,
        KIND_CLEAR  = 3'd5,
        KIND_RSV6   = 3'd6,
        KIND_RSV7   = 3'd7
    } kind_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [30:0] page_id;
        logic        dirty;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [3:0]  slot;
        logic [30:0] page_id_out;
        logic        victim_valid;
        logic        write_back;
        logic        last;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_UPDATE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// File: rtl/lru_page_cache_directory_core.sv
// ----------------------------------------------------------------------------
// lru_page_cache_directory_core
// Fully associative page directory with valid, dirty and exact LRU ranks.
// ----------------------------------------------------------------------------
// Channel  | Signals           | Transfer
// ---------+-------------------+------------------------------------------
// request  | start, busy, req  | start high and busy low at rising edge
// result   | rsp_valid, rsp    | one cycle strobe, receiver cannot stall
//
// A request holds busy through the search walk, in which one shared
// comparator walks the slots one per cycle behind the registered page read
// (free slot and victim are picked in the same walk), then through the victim
// page read, an update state of independent per-slot rank adds and a done
// state that carries the result strobe.
// A dirty scan holds busy while it walks the slots and strobes each dirty slot
// the cycle after it is walked; with none dirty, its one result strobes in
// the same cycle that busy drops. The next transfer can land as soon as
// busy drops.
// Reset clears valid, dirty and ranks; slot pages are kept in a memory.
// ----------------------------------------------------------------------------
`include "lru_page_cache_directory_core_macros.svh"

module lru_page_cache_directory_core #(
    parameter int CAPACITY = lpcd_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  lpcd_pkg::req_t req,
    output logic          busy,
    output logic          rsp_valid,
    output lpcd_pkg::rsp_t rsp
);
    import lpcd_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = IW;

    // slot state
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [CAPACITY-1:0] dirty_reg, dirty_next;
    logic [RW-1:0]       rank_reg [CAPACITY];
    logic [RW-1:0]       rank_next [CAPACITY];
    logic [30:0]         page_mem [CAPACITY];

    // sequencer
    state_t      state_reg, state_next;
    req_t        req_reg;
    logic [CW-1:0] idx_reg, idx_next;
    logic [IW-1:0] idx_i;
    logic        found_reg, found_next;
    logic [IW-1:0] hit_reg, hit_next;
    logic        free_reg, free_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [IW-1:0] vic_reg, vic_next;
    logic [4:0]  nres_reg, nres_next;
    logic [30:0] rd_page;
    logic        rsp_valid_next;
    rsp_t        rsp_next;

    assign idx_i = idx_reg[IW-1:0];

    // single read port, address from walk counter or target slot
    logic [IW-1:0] rd_addr;
    always_comb
    begin
        rd_addr = idx_i;
        if (state_reg == ST_DECIDE)
            rd_addr = vic_reg;
    end
    always_ff @(posedge clk)
    begin
        rd_page <= page_mem[rd_addr];
    end

    // page write on put miss
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    always_ff @(posedge clk)
    begin
        if (wr_en)
            page_mem[wr_addr] <= req_reg.page_id;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = (kind_t'(req.kind) == KIND_SCAN) ? ST_SCAN : ST_SEARCH;
            ST_SEARCH:
                if (idx_reg == CW'(CAPACITY))
                    state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_DONE;
            ST_SCAN:
                if (idx_reg == CW'(CAPACITY) || nres_reg == 5'(MAX_RESULTS))
                    state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        logic [RW-1:0] lim;
        logic          touch;
        logic [IW-1:0] ts;
        logic          s_valid;
        logic          s_dirty;
        s_valid        = 1'b0;
        s_dirty        = 1'b0;
        lim            = '0;
        touch          = 1'b0;
        ts             = '0;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        rank_next      = rank_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        hit_next       = hit_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        vic_next       = vic_reg;
        nres_next      = nres_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        rsp_valid_next = 1'b0;
        rsp_next       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next   = '0;
                found_next = 1'b0;
                free_next  = 1'b0;
                vic_next   = '0;
                nres_next  = '0;
            end
            ST_SEARCH:
            begin
                // rd_page holds page of slot idx-1
                if (idx_reg != '0)
                begin
                    ts = IW'(idx_reg - CW'(1));
                    s_valid = valid_reg[ts];
                    if (!found_reg && s_valid && rd_page == req_reg.page_id)
                    begin
                        found_next = 1'b1;
                        hit_next   = ts;
                    end
                    if (!free_reg && !s_valid)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = ts;
                    end
                    if (rank_reg[ts] > rank_reg[vic_reg])
                        vic_next = ts;
                end
                if (idx_reg != CW'(CAPACITY))
                    idx_next = idx_reg + CW'(1);
            end
            ST_DECIDE: ;  // victim page read in flight
            ST_UPDATE:
            begin
                rsp_valid_next = 1'b1;
                rsp_next.last  = 1'b1;
                unique case (kind_t'(req_reg.kind))
                    KIND_LOOKUP, KIND_PROBE, KIND_MARK:
                    begin
                        rsp_next.hit  = found_reg;
                        rsp_next.slot = found_reg ? 4'(hit_reg) : 4'd0;
                        if (found_reg && kind_t'(req_reg.kind) == KIND_LOOKUP)
                        begin
                            touch = 1'b1; ts = hit_reg; lim = rank_reg[hit_reg];
                        end
                        if (found_reg && kind_t'(req_reg.kind) == KIND_MARK)
                            dirty_next[hit_reg] = 1'b1;
                    end
                    KIND_PUT:
                    begin
                        touch = 1'b1;
                        if (found_reg)
                        begin
                            ts = hit_reg; lim = rank_reg[hit_reg];
                            dirty_next[hit_reg] = req_reg.dirty;
                            rsp_next.hit  = 1'b1;
                            rsp_next.slot = 4'(hit_reg);
                        end
                        else
                        begin
                            ts  = free_reg ? free_idx_reg : vic_reg;
                            lim = '1;
                            rsp_next.slot = 4'(ts);
                            if (!free_reg)
                            begin
                                rsp_next.victim_valid = 1'b1;
                                rsp_next.write_back   = dirty_reg[vic_reg];
                                rsp_next.page_id_out  = rd_page;
                            end
                            wr_en = 1'b1;
                            wr_addr = ts;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        valid_next = '0;
                        dirty_next = '0;
                        for (int i = 0; i < CAPACITY; i++)
                            rank_next[i] = '0;
                    end
                    default: ;
                endcase
                if (touch)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                        if (valid_reg[i] && IW'(i) != ts &&
                            (rank_reg[i] < lim || lim == '1))
                            rank_next[i] = rank_reg[i] + RW'(1);
                    rank_next[ts] = '0;
                    if (kind_t'(req_reg.kind) == KIND_PUT && !found_reg)
                    begin
                        valid_next[ts] = 1'b1;
                        dirty_next[ts] = req_reg.dirty;
                    end
                end
            end
            ST_SCAN:
            begin
                if (idx_reg != '0)
                begin
                    ts = IW'(idx_reg - CW'(1));
                    s_dirty = valid_reg[ts] && dirty_reg[ts];
                    if (s_dirty && nres_reg != 5'(MAX_RESULTS))
                    begin
                        rsp_valid_next       = 1'b1;
                        rsp_next.hit         = 1'b1;
                        rsp_next.slot        = 4'(ts);
                        rsp_next.page_id_out = rd_page;
                        nres_next            = nres_reg + 5'd1;
                        // last when no further dirty slot would be emitted
                        rsp_next.last        = (nres_reg == 5'(MAX_RESULTS - 1));
                        if (idx_reg != CW'(CAPACITY))
                        begin
                            rsp_next.last = rsp_next.last ||
                                ((valid_reg & dirty_reg) >> idx_reg) == '0;
                        end
                        else
                            rsp_next.last = 1'b1;
                    end
                end
                if (idx_reg != CW'(CAPACITY))
                    idx_next = idx_reg + CW'(1);
            end
            ST_DONE:
            begin
                if (req_reg.kind == KIND_SCAN && nres_reg == '0)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.last  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            dirty_reg <= '0;
            for (int i = 0; i < CAPACITY; i++)
                rank_reg[i] <= '0;
            rsp_valid <= 1'b0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
            nres_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            rank_reg  <= rank_next;
            rsp_valid <= rsp_valid_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            free_reg  <= free_next;
            nres_reg  <= nres_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
            req_reg <= req;
        hit_reg      <= hit_next;
        free_idx_reg <= free_idx_next;
        vic_reg      <= vic_next;
        rsp          <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);

    `LPCD_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "busy not raised")
    `LPCD_ASSERT_IMP(a_no_rsp_idle, clk, rst_n, rsp_valid && !$past(busy), 1'b0,
        "result without request")
    `LPCD_ASSERT_IMP(a_scan_cap, clk, rst_n, 1'b1, nres_reg <= 5'(MAX_RESULTS),
        "scan count overflow")

endmodule
